@@ rtl/hgcd_pkg.sv @@
// Shared constants, types and helper functions for the haversine distance block.
// Holds the CORDIC angle table, the degree-to-radian scale and the CORDIC gain.
// Depends on nothing; every other file refers to it by scoped names.
package hgcd_pkg;

	// Fixed-point configuration.
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int DIST_FRAC_BITS  = 8;
	localparam int CORDIC_STAGES   = 20;

	// Physical constants.
	localparam int HalfTurnDeg   = 180;
	localparam int EarthRadiusKm = 6371;
	localparam int AngleFactor   = 2;

	// Port and datapath widths.
	localparam int LatW    = 24;
	localparam int LonW    = 25;
	localparam int OutW    = 23;
	localparam int DegW    = 27;
	localparam int ThetaW  = ANGLE_FRAC_BITS + 8;
	localparam int OneBits = 30;
	localparam int FracW   = OneBits + 1;
	localparam int XW      = 34;
	localparam int StepW   = $clog2(CORDIC_STAGES);
	localparam int SqSteps = OneBits + 1;
	localparam int SqStepW = $clog2(SqSteps);
	localparam int SqVW    = 2 * OneBits + 1;
	localparam int SqRW    = 2 * OneBits + 2;
	localparam int ProdW   = FracW + 14;
	localparam int DistW   = ProdW + 17;

	// Latencies of the pipeline sections.
	localparam int ScLat   = CORDIC_STAGES + 3;
	localparam int NumStg  = 2 * CORDIC_STAGES + 40;

	// Angle ranges in input units.
	localparam int FullTurn    = 2 * HalfTurnDeg * (1 << ANGLE_FRAC_BITS);
	localparam int HalfTurn    = HalfTurnDeg * (1 << ANGLE_FRAC_BITS);
	localparam int QuarterTurn = HalfTurn / 2;

	localparam logic [FracW-1:0] OneQ30 = FracW'(1) << OneBits;
	localparam logic [13:0] DistScale = 14'(AngleFactor * EarthRadiusKm);
	localparam logic [31:0] OutMax = (32'd1 << OutW) - 32'd1;

	// Pi in Q61 and the scale from half-angle units to Q30 radians.
	localparam logic [63:0] Pi61 = 64'h6487ED5110B4611A;
	localparam logic [63:0] RadScale =
		((Pi61 >> (ANGLE_FRAC_BITS + 2)) + 64'(HalfTurnDeg / 2)) / 64'(HalfTurnDeg);
	localparam logic [23:0] RadLo = RadScale[23:0];
	localparam logic [23:0] RadHi = RadScale[47:24];

	// One CORDIC vector as it travels along the chain.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
	} cordic_t;

	// Arctangent of 2^-i in Q30, rounded to nearest.
	function automatic longint atan_q30(input int i);
		longint r;
		case (i)
			0: r = 64'sd843314857;
			1: r = 64'sd497837829;
			2: r = 64'sd263043837;
			3: r = 64'sd133525159;
			4: r = 64'sd67021687;
			5: r = 64'sd33543516;
			6: r = 64'sd16775851;
			7: r = 64'sd8388437;
			8: r = 64'sd4194283;
			9: r = 64'sd2097149;
			default: r = (i >= 31) ? 64'sd1 : (64'sd1 <<< (30 - i));
		endcase
		return r;
	endfunction

	// Runs the rotation chain on a unit vector to get the chain's gain.
	function automatic longint cordic_gain();
		longint x;
		longint y;
		longint z;
		longint nx;
		longint ny;
		x = 64'sd1 <<< OneBits;
		y = 64'sd0;
		z = 64'sd0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z  = z - atan_q30(i);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z  = z + atan_q30(i);
			end
			x = nx;
			y = ny;
		end
		return x;
	endfunction

	localparam longint Gain    = cordic_gain();
	localparam longint InvGain = ((64'sd1 <<< 60) + Gain / 2) / Gain;

	// Clamps a signed Q30 value to the range zero to one.
	function automatic logic [FracW-1:0] clamp01(input logic signed [XW-1:0] v);
		logic [FracW-1:0] r;
		if (v[XW-1]) begin
			r = '0;
		end else if (v > $signed({{(XW-FracW){1'b0}}, OneQ30})) begin
			r = OneQ30;
		end else begin
			r = v[FracW-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/hgcd_cell.sv @@
// One CORDIC micro-rotation cell with a register on its output.
// Works in rotation or vectoring mode; the step index sets shift and angle.
// Depends on hgcd_pkg.
module hgcd_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        vectoring,
	input  logic [hgcd_pkg::StepW-1:0]  step,
	input  hgcd_pkg::cordic_t           din,
	output hgcd_pkg::cordic_t           dout
);

	logic signed [hgcd_pkg::XW-1:0] x_in;
	logic signed [hgcd_pkg::XW-1:0] y_in;
	logic signed [hgcd_pkg::XW-1:0] z_in;
	logic signed [hgcd_pkg::XW-1:0] xs;
	logic signed [hgcd_pkg::XW-1:0] ys;
	logic signed [hgcd_pkg::XW-1:0] at;
	logic                           dir;
	hgcd_pkg::cordic_t              nxt;
	hgcd_pkg::cordic_t              dout_q;

	// Shifted terms and the angle of this step.
	assign x_in = din.x;
	assign y_in = din.y;
	assign z_in = din.z;
	assign xs   = x_in >>> step;
	assign ys   = y_in >>> step;
	assign at   = hgcd_pkg::XW'(hgcd_pkg::atan_q30(int'(step)));

	// Rotation follows the sign of z; vectoring drives y toward zero.
	assign dir = vectoring ? y_in[hgcd_pkg::XW-1] : !z_in[hgcd_pkg::XW-1];

	always_comb begin
		if (dir) begin
			nxt.x = x_in - ys;
			nxt.y = y_in + xs;
			nxt.z = z_in - at;
		end else begin
			nxt.x = x_in + ys;
			nxt.y = y_in - xs;
			nxt.z = z_in + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

	assign dout = dout_q;

endmodule

@@ rtl/hgcd_sqrt_cell.sv @@
// One digit step of a restoring square root with a register on its output.
// The step index selects which result bit this cell settles.
// Depends on hgcd_pkg.
module hgcd_sqrt_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hgcd_pkg::SqStepW-1:0]  step,
	input  logic [hgcd_pkg::SqVW-1:0]     v_in,
	input  logic [hgcd_pkg::SqRW-1:0]     r_in,
	output logic [hgcd_pkg::SqVW-1:0]     v_out,
	output logic [hgcd_pkg::SqRW-1:0]     r_out
);

	logic [hgcd_pkg::SqRW-1:0] bit_w;
	logic [hgcd_pkg::SqRW-1:0] trial;
	logic                      ge;
	logic [hgcd_pkg::SqVW-1:0] v_nx;
	logic [hgcd_pkg::SqRW-1:0] r_nx;
	logic [hgcd_pkg::SqVW-1:0] v_q;
	logic [hgcd_pkg::SqRW-1:0] r_q;

	// Trial bit for this digit, counting down from the top.
	assign bit_w = hgcd_pkg::SqRW'(1) << (hgcd_pkg::SqRW'(2 * (hgcd_pkg::SqSteps - 1))
		- (hgcd_pkg::SqRW'(step) << 1));
	assign trial = r_in + bit_w;
	assign ge    = hgcd_pkg::SqRW'(v_in) >= trial;

	always_comb begin
		if (ge) begin
			v_nx = v_in - trial[hgcd_pkg::SqVW-1:0];
			r_nx = (r_in >> 1) + bit_w;
		end else begin
			v_nx = v_in;
			r_nx = r_in >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q <= v_nx;
			r_q <= r_nx;
		end
	end

	assign v_out = v_q;
	assign r_out = r_q;

endmodule

@@ rtl/hgcd_sincos.sv @@
// Sine and cosine of a half-angle in degree units through a rotation CORDIC chain.
// Converts to Q30 radians with a split multiply, then clamps both results to 0..1.
// Depends on hgcd_pkg and hgcd_cell.
module hgcd_sincos (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hgcd_pkg::ThetaW-1:0]   theta,
	output logic [hgcd_pkg::FracW-1:0]    sin_val,
	output logic [hgcd_pkg::FracW-1:0]    cos_val
);

	localparam int PW = hgcd_pkg::ThetaW + 24;
	localparam int SW = PW + 24;

	logic [PW-1:0]                  plo_s1;
	logic [PW-1:0]                  phi_s1;
	logic [SW-1:0]                  zsum;
	hgcd_pkg::cordic_t              init_s2;
	hgcd_pkg::cordic_t              chain [hgcd_pkg::CORDIC_STAGES+1];
	logic [hgcd_pkg::FracW-1:0]     sin_q;
	logic [hgcd_pkg::FracW-1:0]     cos_q;

	// Degree to radian scaling as two partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= PW'(theta) * PW'(hgcd_pkg::RadLo);
			phi_s1 <= PW'(theta) * PW'(hgcd_pkg::RadHi);
		end
	end

	// Sum the partial products and load the starting vector.
	assign zsum = (SW'(phi_s1) << 24) + SW'(plo_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			init_s2.x <= hgcd_pkg::XW'(hgcd_pkg::InvGain);
			init_s2.y <= '0;
			init_s2.z <= zsum[hgcd_pkg::OneBits+hgcd_pkg::XW-1:hgcd_pkg::OneBits];
		end
	end

	assign chain[0] = init_s2;

	// Rotation cells, one per step.
	for (genvar g = 0; g < hgcd_pkg::CORDIC_STAGES; g++) begin : g_rot
		hgcd_cell u_cell (
			.clk       (clk),
			.en        (en),
			.vectoring (1'b0),
			.step      (hgcd_pkg::StepW'(g)),
			.din       (chain[g]),
			.dout      (chain[g+1])
		);
	end

	// Clamp away the small excursions of the chain.
	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= hgcd_pkg::clamp01(chain[hgcd_pkg::CORDIC_STAGES].y);
			cos_q <= hgcd_pkg::clamp01(chain[hgcd_pkg::CORDIC_STAGES].x);
		end
	end

	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

@@ rtl/haversine_great_circle_distance.sv @@
// Haversine great-circle distance between two points given in fixed-point degrees.
// Depends on hgcd_pkg, hgcd_sincos, hgcd_cell and hgcd_sqrt_cell.
//
// The block takes one point pair per clock cycle while request_stall is low and
// returns one distance per pair, in km with eight fraction bits, in request
// order. Every arithmetic step is a registered cell in one long pipeline, so the
// throughput is one pair per cycle while it moves. The pipeline has two input
// stages, the sine/cosine CORDIC chains, two multiply stages, a sum-and-clamp
// stage, a 31-cell square-root chain, the vectoring CORDIC chain for the
// arctangent and one scaling multiply. A two-entry result buffer follows; the
// whole pipeline holds only while that buffer is full, and request_stall is high
// exactly then. Angles outside the nominal ranges are reduced modulo 360 degrees.
module haversine_great_circle_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                request_valid,
	output logic                                request_stall,
	input  logic signed [hgcd_pkg::LatW-1:0]    first_latitude,
	input  logic signed [hgcd_pkg::LonW-1:0]    first_longitude,
	input  logic signed [hgcd_pkg::LatW-1:0]    second_latitude,
	input  logic signed [hgcd_pkg::LonW-1:0]    second_longitude,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [hgcd_pkg::OutW-1:0]           distance_km
);

	localparam int DW = hgcd_pkg::DegW;
	localparam int TW = hgcd_pkg::ThetaW;
	localparam int FW = hgcd_pkg::FracW;
	localparam int XW = hgcd_pkg::XW;
	localparam int NS = hgcd_pkg::CORDIC_STAGES;
	localparam int QS = hgcd_pkg::SqSteps;

	// Reduces a degree value to the half-open range of minus to plus half a turn.
	function automatic logic signed [DW-1:0] wrap_deg(input logic signed [DW-1:0] d);
		logic signed [DW-1:0] m;
		m = d;
		if (m >= DW'(hgcd_pkg::HalfTurn)) begin
			m = m - DW'(hgcd_pkg::FullTurn);
		end
		if (m >= DW'(hgcd_pkg::HalfTurn)) begin
			m = m - DW'(hgcd_pkg::FullTurn);
		end
		if (m < -DW'(hgcd_pkg::HalfTurn)) begin
			m = m + DW'(hgcd_pkg::FullTurn);
		end
		if (m < -DW'(hgcd_pkg::HalfTurn)) begin
			m = m + DW'(hgcd_pkg::FullTurn);
		end
		return m;
	endfunction

	// Magnitude of a wrapped degree value.
	function automatic logic [DW-1:0] abs_deg(input logic signed [DW-1:0] d);
		return d[DW-1] ? DW'(-d) : DW'(d);
	endfunction

	logic                           en;
	logic                           accept;
	logic [hgcd_pkg::NumStg-1:0]    vld_q;

	logic signed [DW-1:0]           dlat_s1;
	logic signed [DW-1:0]           dlon_s1;
	logic signed [DW-1:0]           lat1_s1;
	logic signed [DW-1:0]           lat2_s1;

	logic [DW-1:0]                  a_dlat;
	logic [DW-1:0]                  a_dlon;
	logic [DW-1:0]                  a_lat1;
	logic [DW-1:0]                  a_lat2;
	logic                           fold1;
	logic                           fold2;
	logic [DW-1:0]                  f_lat1;
	logic [DW-1:0]                  f_lat2;

	logic [TW-1:0]                  th_dlat_s2;
	logic [TW-1:0]                  th_dlon_s2;
	logic [TW-1:0]                  th_lat1_s2;
	logic [TW-1:0]                  th_lat2_s2;
	logic                           neg_s2;
	logic                           neg_dly_q [hgcd_pkg::ScLat];

	logic [FW-1:0]                  sl;
	logic [FW-1:0]                  so;
	logic [FW-1:0]                  c1;
	logic [FW-1:0]                  c2;

	logic [2*FW-1:0]                sl_sq;
	logic [2*FW-1:0]                so_sq;
	logic [2*FW-1:0]                c_pr;
	logic [FW-1:0]                  sl2_s26;
	logic [FW-1:0]                  so2_s26;
	logic [FW-1:0]                  cp_s26;
	logic                           neg_s26;

	logic [2*FW-1:0]                t_pr;
	logic [FW-1:0]                  t_s27;
	logic [FW-1:0]                  sl2_s27;
	logic                           neg_s27;

	logic signed [XW-1:0]           h_raw;
	logic [FW-1:0]                  h_s28;

	logic [hgcd_pkg::SqVW-1:0]      sqv_h [QS+1];
	logic [hgcd_pkg::SqRW-1:0]      sqr_h [QS+1];
	logic [hgcd_pkg::SqVW-1:0]      sqv_x [QS+1];
	logic [hgcd_pkg::SqRW-1:0]      sqr_x [QS+1];

	hgcd_pkg::cordic_t              vec [NS+1];
	logic signed [XW-1:0]           z_end;
	logic [FW-1:0]                  z_clamp;
	logic [hgcd_pkg::ProdW-1:0]     prod_s80;

	logic [hgcd_pkg::DistW-1:0]     dsum;
	logic [31:0]                    dq;
	logic [hgcd_pkg::OutW-1:0]      dist_sat;

	logic [1:0]                     cnt_q;
	logic [hgcd_pkg::OutW-1:0]      ent_q [2];
	logic                           push;
	logic                           pop;

	// The pipeline moves unless the result buffer is full.
	assign en            = (cnt_q != 2'd2);
	assign request_stall = !en;
	assign accept        = request_valid && en;

	// Request valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[hgcd_pkg::NumStg-2:0], accept};
		end
	end

	// Stage 1: coordinate differences and the two latitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= DW'(second_latitude) - DW'(first_latitude);
			dlon_s1 <= DW'(second_longitude) - DW'(first_longitude);
			lat1_s1 <= DW'(first_latitude);
			lat2_s1 <= DW'(second_latitude);
		end
	end

	// Stage 2: range reduction and folding of latitudes past the pole.
	assign a_dlat = abs_deg(wrap_deg(dlat_s1));
	assign a_dlon = abs_deg(wrap_deg(dlon_s1));
	assign a_lat1 = abs_deg(wrap_deg(lat1_s1));
	assign a_lat2 = abs_deg(wrap_deg(lat2_s1));
	assign fold1  = a_lat1 > DW'(hgcd_pkg::QuarterTurn);
	assign fold2  = a_lat2 > DW'(hgcd_pkg::QuarterTurn);
	assign f_lat1 = fold1 ? DW'(hgcd_pkg::HalfTurn) - a_lat1 : a_lat1;
	assign f_lat2 = fold2 ? DW'(hgcd_pkg::HalfTurn) - a_lat2 : a_lat2;

	always_ff @(posedge clk) begin
		if (en) begin
			th_dlat_s2 <= a_dlat[TW-1:0];
			th_dlon_s2 <= a_dlon[TW-1:0];
			th_lat1_s2 <= TW'(f_lat1 << 1);
			th_lat2_s2 <= TW'(f_lat2 << 1);
			neg_s2     <= fold1 ^ fold2;
		end
	end

	// Sine and cosine chains.
	hgcd_sincos u_sc_dlat (
		.clk (clk), .en (en), .theta (th_dlat_s2), .sin_val (sl), .cos_val ()
	);
	hgcd_sincos u_sc_dlon (
		.clk (clk), .en (en), .theta (th_dlon_s2), .sin_val (so), .cos_val ()
	);
	hgcd_sincos u_sc_lat1 (
		.clk (clk), .en (en), .theta (th_lat1_s2), .sin_val (), .cos_val (c1)
	);
	hgcd_sincos u_sc_lat2 (
		.clk (clk), .en (en), .theta (th_lat2_s2), .sin_val (), .cos_val (c2)
	);

	// Sign of the longitude term, delayed to match the chains.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_dly_q[0] <= neg_s2;
			for (int k = 1; k < hgcd_pkg::ScLat; k++) begin
				neg_dly_q[k] <= neg_dly_q[k-1];
			end
		end
	end

	// Squared sines and the cosine product.
	assign sl_sq = (2*FW)'(sl) * (2*FW)'(sl);
	assign so_sq = (2*FW)'(so) * (2*FW)'(so);
	assign c_pr  = (2*FW)'(c1) * (2*FW)'(c2);

	always_ff @(posedge clk) begin
		if (en) begin
			sl2_s26 <= sl_sq[hgcd_pkg::OneBits+FW-1:hgcd_pkg::OneBits];
			so2_s26 <= so_sq[hgcd_pkg::OneBits+FW-1:hgcd_pkg::OneBits];
			cp_s26  <= c_pr[hgcd_pkg::OneBits+FW-1:hgcd_pkg::OneBits];
			neg_s26 <= neg_dly_q[hgcd_pkg::ScLat-1];
		end
	end

	// Longitude term weighted by the cosines.
	assign t_pr = (2*FW)'(so2_s26) * (2*FW)'(cp_s26);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s27   <= t_pr[hgcd_pkg::OneBits+FW-1:hgcd_pkg::OneBits];
			sl2_s27 <= sl2_s26;
			neg_s27 <= neg_s26;
		end
	end

	// Haversine value, clamped to 0..1.
	assign h_raw = neg_s27 ? XW'(sl2_s27) - XW'(t_s27) : XW'(sl2_s27) + XW'(t_s27);

	always_ff @(posedge clk) begin
		if (en) begin
			h_s28 <= hgcd_pkg::clamp01(h_raw);
		end
	end

	// Square roots of h and of 1 - h.
	assign sqv_h[0] = hgcd_pkg::SqVW'(h_s28) << hgcd_pkg::OneBits;
	assign sqv_x[0] = hgcd_pkg::SqVW'(hgcd_pkg::OneQ30 - h_s28) << hgcd_pkg::OneBits;
	assign sqr_h[0] = '0;
	assign sqr_x[0] = '0;

	for (genvar g = 0; g < QS; g++) begin : g_sqrt
		hgcd_sqrt_cell u_sq_h (
			.clk   (clk),
			.en    (en),
			.step  (hgcd_pkg::SqStepW'(g)),
			.v_in  (sqv_h[g]),
			.r_in  (sqr_h[g]),
			.v_out (sqv_h[g+1]),
			.r_out (sqr_h[g+1])
		);
		hgcd_sqrt_cell u_sq_x (
			.clk   (clk),
			.en    (en),
			.step  (hgcd_pkg::SqStepW'(g)),
			.v_in  (sqv_x[g]),
			.r_in  (sqr_x[g]),
			.v_out (sqv_x[g+1]),
			.r_out (sqr_x[g+1])
		);
	end

	// Arctangent of sqrt(h) over sqrt(1 - h) by vectoring.
	assign vec[0].x = {{(XW-FW){1'b0}}, sqr_x[QS][FW-1:0]};
	assign vec[0].y = {{(XW-FW){1'b0}}, sqr_h[QS][FW-1:0]};
	assign vec[0].z = '0;

	for (genvar g = 0; g < NS; g++) begin : g_vec
		hgcd_cell u_cell (
			.clk       (clk),
			.en        (en),
			.vectoring (1'b1),
			.step      (hgcd_pkg::StepW'(g)),
			.din       (vec[g]),
			.dout      (vec[g+1])
		);
	end

	// Scale the angle by twice the radius.
	assign z_end   = vec[NS].z;
	assign z_clamp = z_end[XW-1] ? '0 : z_end[FW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s80 <= hgcd_pkg::ProdW'(z_clamp) * hgcd_pkg::ProdW'(hgcd_pkg::DistScale);
		end
	end

	// Round half up and saturate to the output field.
	assign dsum     = (hgcd_pkg::DistW'(prod_s80) << hgcd_pkg::DIST_FRAC_BITS)
		+ (hgcd_pkg::DistW'(1) << (hgcd_pkg::OneBits - 1));
	assign dq       = dsum[hgcd_pkg::OneBits+31:hgcd_pkg::OneBits];
	assign dist_sat = (dq > hgcd_pkg::OutMax) ? hgcd_pkg::OutMax[hgcd_pkg::OutW-1:0]
		: dq[hgcd_pkg::OutW-1:0];

	// Two-entry result buffer.
	assign push = en && vld_q[hgcd_pkg::NumStg-1];
	assign pop  = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// The head entry takes a new result when it is empty or being drained.
	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || pop)) begin
			ent_q[0] <= dist_sat;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
		if (push && cnt_q[0] && !pop) begin
			ent_q[1] <= dist_sat;
		end
	end

	assign result_valid = (cnt_q != 2'd0);
	assign distance_km  = ent_q[0];

endmodule

@@ rtl/hgcd_checker.sv @@
// Port-level checks for the haversine distance block, attached by bind.
// Depends on hgcd_pkg and on the top level's port list.
module hgcd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              request_valid,
	input logic                              request_stall,
	input logic signed [hgcd_pkg::LatW-1:0]  first_latitude,
	input logic signed [hgcd_pkg::LonW-1:0]  first_longitude,
	input logic signed [hgcd_pkg::LatW-1:0]  second_latitude,
	input logic signed [hgcd_pkg::LonW-1:0]  second_longitude,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic [hgcd_pkg::OutW-1:0]         distance_km
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(distance_km))
		else $error("stalled result changed");

	// A result leaves only when it is taken.
	a_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result dropped without being taken");

	// Requests are held back only while a result is waiting.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		request_stall |-> result_valid)
		else $error("request stalled with no result waiting");

	// The buffer fills only when the previous result was not taken.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(request_stall) |-> $past(result_valid && result_stall))
		else $error("request stall rose while results drained");

endmodule

bind haversine_great_circle_distance hgcd_checker u_hgcd_checker (.*);
